### design/ctc_pkg.sv
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared types and constants for the countdown timer controller: mode,
// event, message and status codes, field widths and register reset values.
// ----------------------------------------------------------------------------
package ctc_pkg;

    localparam int unsigned CMD_W   = 2;
    localparam int unsigned PHASE_W = 4;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned DISP_W  = 16;
    localparam int unsigned MSG_W   = 3;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned STEP_W  = 10;
    localparam int unsigned SET_W   = 16;
    localparam int unsigned PROD_W  = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = STEP_W;

    localparam logic [STEP_W-1:0]  STEP_RESET         = 10'd60;
    localparam logic [PHASE_W-1:0] BEEP_PHASE_RESET   = 4'd5;
    localparam logic [PHASE_W-1:0] SECOND_PHASE_RESET = 4'd10;

    typedef enum logic [MODE_W-1:0] {
        M_IDLE  = 3'd0,
        M_SET   = 3'd1,
        M_COUNT = 3'd2,
        M_PAUSE = 3'd3,
        M_STAT  = 3'd4
    } mode_t;

    typedef enum logic [CMD_W-1:0] {
        EV_TICK  = 2'd0,
        EV_INC   = 2'd1,
        EV_DEC   = 2'd2,
        EV_START = 2'd3
    } cmd_t;

    typedef enum logic [MSG_W-1:0] {
        MSG_NONE    = 3'd0,
        MSG_SETTIME = 3'd1,
        MSG_PROD    = 3'd2,
        MSG_PAUSED  = 3'd3,
        MSG_CLEAR   = 3'd4
    } msg_t;

    typedef enum logic [STAT_W-1:0] {
        ST_IGNORED = 2'd0,
        ST_HANDLED = 2'd1,
        ST_TRANS   = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP         = 2'd0,
        CFG_BEEP_PHASE   = 2'd1,
        CFG_SECOND_PHASE = 2'd2
    } cfg_idx_t;

endpackage

### design/countdown_timer_controller.sv
// ----------------------------------------------------------------------------
// countdown_timer_controller
// Five-mode countdown timer state machine: one event word in, one result
// word out, with set, elapsed and productive time kept in saturating counters.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_cmd, s_phase
//  m_      | out       | m_valid / m_ready  | m_mode, m_show_time, m_display_seconds,
//          |           |                    | m_message, m_beep, m_status
//  cfg_    | in        | cfg_we             | cfg_index, cfg_wdata
//
// one event word per cycle; its result appears in the output register in the
// cycle after acceptance, set by the single mode/counter update between the two
// a new word is taken while the output register is empty or being drained
// a stalled result holds the input side until m_ready rises
// reset (aresetn low, synchronous) puts the timer in idle with all counts zero
// ----------------------------------------------------------------------------
module countdown_timer_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    // event channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ctc_pkg::CMD_W-1:0]         s_cmd,
    input  logic [ctc_pkg::PHASE_W-1:0]       s_phase,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ctc_pkg::MODE_W-1:0]        m_mode,
    output logic                              m_show_time,
    output logic [ctc_pkg::DISP_W-1:0]        m_display_seconds,
    output logic [ctc_pkg::MSG_W-1:0]         m_message,
    output logic                              m_beep,
    output logic [ctc_pkg::STAT_W-1:0]        m_status,
    // configuration
    input  logic                              cfg_we,
    input  logic [ctc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ctc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import ctc_pkg::*;

    logic [STEP_W-1:0]  step_reg;
    logic [PHASE_W-1:0] beep_phase_reg;
    logic [PHASE_W-1:0] second_phase_reg;

    mode_t              mode_reg, mode_next;
    logic [SET_W-1:0]   set_reg, set_next;
    logic [SET_W-1:0]   elapsed_reg, elapsed_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;

    logic               m_valid_reg;
    mode_t              m_mode_reg;
    logic               m_show_reg, show_next;
    logic [DISP_W-1:0]  m_disp_reg, disp_next;
    msg_t               m_msg_reg, msg_next;
    logic               m_beep_reg, beep_next;
    status_t            m_status_reg, status_next;

    logic               accept;
    cmd_t               cmd;
    logic               tick_sec;
    logic               tick_beep;
    logic [SET_W:0]     set_plus;
    logic [SET_W-1:0]   set_inc;
    logic               dec_ok;
    logic [SET_W-1:0]   set_dec;
    logic [SET_W-1:0]   set_m1;
    logic [SET_W-1:0]   elapsed_inc;
    logic [SET_W-1:0]   elapsed_exit;
    logic [PROD_W:0]    prod_sum;
    logic [PROD_W-1:0]  prod_exit;
    logic [DISP_W-1:0]  prod_disp;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign cmd     = cmd_t'(s_cmd);

    // ---------------- shared arithmetic ----------------
    assign tick_sec  = (cmd == EV_TICK) && (s_phase == second_phase_reg);
    assign tick_beep = (cmd == EV_TICK) && (s_phase == beep_phase_reg);

    assign set_plus = {1'b0, set_reg} + {{(SET_W+1-STEP_W){1'b0}}, step_reg};
    assign set_inc  = set_plus[SET_W] ? {SET_W{1'b1}} : set_plus[SET_W-1:0];
    assign dec_ok   = set_reg >= {{(SET_W-STEP_W){1'b0}}, step_reg};
    assign set_dec  = set_reg - {{(SET_W-STEP_W){1'b0}}, step_reg};
    assign set_m1   = set_reg - {{(SET_W-1){1'b0}}, 1'b1};

    assign elapsed_inc = (elapsed_reg == {SET_W{1'b1}}) ? elapsed_reg
                       : elapsed_reg + {{(SET_W-1){1'b0}}, 1'b1};

    // a countdown tick that lands on zero counts its second before leaving
    assign elapsed_exit = (cmd == EV_TICK && set_reg != '0) ? elapsed_inc : elapsed_reg;
    assign prod_sum  = {1'b0, prod_reg} + {{(PROD_W+1-SET_W){1'b0}}, elapsed_exit};
    assign prod_exit = prod_sum[PROD_W] ? {PROD_W{1'b1}} : prod_sum[PROD_W-1:0];
    assign prod_disp = (prod_reg[PROD_W-1:DISP_W] != '0) ? {DISP_W{1'b1}}
                     : prod_reg[DISP_W-1:0];

    // ---------------- next mode ----------------
    always_comb begin
        mode_next = mode_reg;
        unique case (mode_reg)
            M_IDLE: begin
                if (cmd == EV_START)     mode_next = M_STAT;
                else if (cmd == EV_INC)  mode_next = M_SET;
            end
            M_SET: begin
                if (cmd == EV_START)     mode_next = M_COUNT;
            end
            M_COUNT: begin
                if (cmd == EV_START)     mode_next = M_PAUSE;
                else if (tick_sec && (set_reg == '0 || set_m1 == '0))
                                         mode_next = M_IDLE;
            end
            M_PAUSE: begin
                if (cmd == EV_START)     mode_next = M_COUNT;
                else if (cmd == EV_INC)  mode_next = M_SET;
                else if (cmd == EV_DEC && dec_ok)
                                         mode_next = M_SET;
            end
            M_STAT: begin
                if (tick_sec)            mode_next = M_IDLE;
            end
            default: mode_next = mode_reg;
        endcase
    end

    // ---------------- counters and result word ----------------
    always_comb begin
        set_next     = set_reg;
        elapsed_next = elapsed_reg;
        prod_next    = prod_reg;
        show_next    = 1'b0;
        disp_next    = '0;
        msg_next     = MSG_NONE;
        beep_next    = 1'b0;
        status_next  = ST_IGNORED;
        unique case (mode_reg)
            M_IDLE: begin
                if (cmd == EV_START) begin
                    set_next     = '0;
                    elapsed_next = '0;
                    show_next    = 1'b1;
                    disp_next    = prod_disp;
                    msg_next     = MSG_PROD;
                    status_next  = ST_TRANS;
                end else if (cmd == EV_INC) begin
                    set_next    = set_inc;
                    show_next   = 1'b1;
                    disp_next   = set_inc;
                    msg_next    = MSG_CLEAR;
                    status_next = ST_TRANS;
                end else if (tick_beep) begin
                    beep_next   = 1'b1;
                    status_next = ST_HANDLED;
                end
            end
            M_SET: begin
                if (cmd == EV_START) begin
                    msg_next    = MSG_CLEAR;
                    status_next = ST_TRANS;
                end else if (cmd == EV_INC) begin
                    set_next    = set_inc;
                    show_next   = 1'b1;
                    disp_next   = set_inc;
                    status_next = ST_HANDLED;
                end else if (cmd == EV_DEC) begin
                    set_next    = dec_ok ? set_dec : set_reg;
                    show_next   = 1'b1;
                    disp_next   = dec_ok ? set_dec : set_reg;
                    status_next = ST_HANDLED;
                end
            end
            M_COUNT: begin
                if (cmd == EV_START) begin
                    prod_next    = prod_exit;
                    elapsed_next = '0;
                    msg_next     = MSG_PAUSED;
                    status_next  = ST_TRANS;
                end else if (cmd == EV_TICK) begin
                    status_next = ST_HANDLED;
                    if (tick_sec) begin
                        if (set_reg == '0 || set_m1 == '0) begin
                            // reaching zero: fold elapsed into productive, back to idle
                            prod_next    = prod_exit;
                            set_next     = '0;
                            elapsed_next = '0;
                            show_next    = 1'b1;
                            disp_next    = '0;
                            msg_next     = MSG_SETTIME;
                            status_next  = ST_TRANS;
                        end else begin
                            set_next     = set_m1;
                            elapsed_next = elapsed_inc;
                            show_next    = 1'b1;
                            disp_next    = set_m1;
                        end
                    end
                end
            end
            M_PAUSE: begin
                if (cmd == EV_START) begin
                    msg_next    = MSG_CLEAR;
                    status_next = ST_TRANS;
                end else if (cmd == EV_INC) begin
                    set_next    = set_inc;
                    show_next   = 1'b1;
                    disp_next   = set_inc;
                    msg_next    = MSG_CLEAR;
                    status_next = ST_TRANS;
                end else if (cmd == EV_DEC && dec_ok) begin
                    set_next    = set_dec;
                    show_next   = 1'b1;
                    disp_next   = set_dec;
                    msg_next    = MSG_CLEAR;
                    status_next = ST_TRANS;
                end
            end
            M_STAT: begin
                if (tick_sec) begin
                    set_next     = '0;
                    elapsed_next = '0;
                    show_next    = 1'b1;
                    disp_next    = '0;
                    msg_next     = MSG_SETTIME;
                    status_next  = ST_TRANS;
                end
            end
            default: status_next = ST_IGNORED;
        endcase
    end

    // ---------------- configuration registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg         <= STEP_RESET;
            beep_phase_reg   <= BEEP_PHASE_RESET;
            second_phase_reg <= SECOND_PHASE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_STEP:         step_reg         <= cfg_wdata;
                CFG_BEEP_PHASE:   beep_phase_reg   <= cfg_wdata[PHASE_W-1:0];
                CFG_SECOND_PHASE: second_phase_reg <= cfg_wdata[PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- timer state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= M_IDLE;
            set_reg     <= '0;
            elapsed_reg <= '0;
            prod_reg    <= '0;
        end else if (accept) begin
            mode_reg    <= mode_next;
            set_reg     <= set_next;
            elapsed_reg <= elapsed_next;
            prod_reg    <= prod_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_mode_reg   <= mode_next;
            m_show_reg   <= show_next;
            m_disp_reg   <= disp_next;
            m_msg_reg    <= msg_next;
            m_beep_reg   <= beep_next;
            m_status_reg <= status_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_mode            = m_mode_reg;
    assign m_show_time       = m_show_reg;
    assign m_display_seconds = m_disp_reg;
    assign m_message         = m_msg_reg;
    assign m_beep            = m_beep_reg;
    assign m_status          = m_status_reg;

    // ---------------- assertions ----------------
    // result word reports the mode the timer actually moved to
    a_mode_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_mode == mode_reg))
        else $error("result mode differs from timer mode");

    // beeps only come from idle
    a_beep_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_beep) |-> (m_mode == M_IDLE))
        else $error("beep outside idle");

    // no redraw means a blank display value
    a_disp_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_show_time) |-> (m_display_seconds == '0))
        else $error("display value without redraw");

    // idle always holds a cleared set time
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == M_IDLE) |-> (set_reg == '0))
        else $error("set time nonzero in idle");

    // elapsed time only accumulates while counting down
    a_elapsed_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != M_COUNT) |-> (elapsed_reg == '0))
        else $error("elapsed time nonzero outside countdown");

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the countdown timer controller. Event words go in
// through a randomly gapped driver and results come out through a randomly
// stalled sink. A built-in model of the five-mode timer predicts every
// result, and each result is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module tb;
    import ctc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned PHASE_ITEMS = 55;

    typedef struct packed {
        cmd_t               cmd;
        logic [PHASE_W-1:0] phase;
    } timer_event_t;

    typedef struct packed {
        mode_t             mode;
        logic              show_time;
        logic [DISP_W-1:0] display_seconds;
        msg_t              message;
        logic              beep;
        status_t           status;
    } timer_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_cmd;
    logic [PHASE_W-1:0]    s_phase;
    logic                  m_valid;
    logic                  m_ready;
    logic [MODE_W-1:0]     m_mode;
    logic                  m_show_time;
    logic [DISP_W-1:0]     m_display_seconds;
    logic [MSG_W-1:0]      m_message;
    logic                  m_beep;
    logic [STAT_W-1:0]     m_status;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    countdown_timer_controller i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_phase           (s_phase),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_mode            (m_mode),
        .m_show_time       (m_show_time),
        .m_display_seconds (m_display_seconds),
        .m_message         (m_message),
        .m_beep            (m_beep),
        .m_status          (m_status),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // timer model state and register copies
    mode_t              pred_mode;
    logic [SET_W-1:0]   pred_set;
    logic [SET_W-1:0]   pred_elapsed;
    logic [PROD_W-1:0]  pred_prod;
    logic [STEP_W-1:0]  pred_step;
    logic [PHASE_W-1:0] pred_beep;
    logic [PHASE_W-1:0] pred_second;
    timer_result_t      pred_out;

    timer_event_t  events_pending[$];
    timer_result_t results_due[$];
    timer_event_t  next_ev;
    timer_result_t due;

    bit                 idling;
    bit                 in_took;
    bit                 out_took;
    int                 send_gap;
    int                 stall_left;
    int unsigned        cycle_count;
    int unsigned        mismatch_count;
    int unsigned        queued_count;
    logic [PHASE_W-1:0] gen_beep;
    logic [PHASE_W-1:0] gen_second;

    function automatic logic [PHASE_W-1:0] rand_phase();
        return PHASE_W'($urandom_range(0, 15));
    endfunction

    function automatic void show_value(logic [PROD_W-1:0] v);
        pred_out.show_time = 1'b1;
        pred_out.display_seconds = (v > 32'hFFFF) ? 16'hFFFF : v[DISP_W-1:0];
    endfunction

    function automatic void add_step();
        logic [SET_W:0] sum;
        sum = {1'b0, pred_set} + (SET_W+1)'(pred_step);
        pred_set = sum[SET_W] ? '1 : sum[SET_W-1:0];
    endfunction

    // exit action of the old mode, then entry action of the new one
    function automatic void change_mode(mode_t to);
        logic [PROD_W:0] sum;
        if (pred_mode == M_COUNT) begin
            sum = {1'b0, pred_prod} + (PROD_W+1)'(pred_elapsed);
            pred_prod = sum[PROD_W] ? '1 : sum[PROD_W-1:0];
            pred_elapsed = '0;
        end else begin
            pred_out.message = MSG_CLEAR;
        end
        pred_mode = to;
        case (to)
            M_IDLE: begin
                pred_set = '0;
                pred_elapsed = '0;
                show_value('0);
                pred_out.message = MSG_SETTIME;
            end
            M_SET: begin
                show_value(PROD_W'(pred_set));
            end
            M_PAUSE: begin
                pred_out.message = MSG_PAUSED;
            end
            M_STAT: begin
                pred_set = '0;
                pred_elapsed = '0;
                show_value(pred_prod);
                pred_out.message = MSG_PROD;
            end
            default: ;
        endcase
        pred_out.status = ST_TRANS;
    endfunction

    function automatic void predict_event(cmd_t cmd, logic [PHASE_W-1:0] phase);
        pred_out = '0;
        case (pred_mode)
            M_IDLE: begin
                if (cmd == EV_START) begin
                    change_mode(M_STAT);
                end else if (cmd == EV_INC) begin
                    add_step();
                    change_mode(M_SET);
                end else if (cmd == EV_TICK && phase == pred_beep) begin
                    pred_out.beep = 1'b1;
                    pred_out.status = ST_HANDLED;
                end
            end
            M_SET: begin
                if (cmd == EV_START) begin
                    change_mode(M_COUNT);
                end else if (cmd == EV_INC) begin
                    add_step();
                    show_value(PROD_W'(pred_set));
                    pred_out.status = ST_HANDLED;
                end else if (cmd == EV_DEC) begin
                    if (pred_set >= pred_step)
                        pred_set = pred_set - pred_step;
                    show_value(PROD_W'(pred_set));
                    pred_out.status = ST_HANDLED;
                end
            end
            M_COUNT: begin
                if (cmd == EV_START) begin
                    change_mode(M_PAUSE);
                end else if (cmd == EV_TICK) begin
                    pred_out.status = ST_HANDLED;
                    if (phase == pred_second) begin
                        // a second tick with nothing left goes straight to idle
                        if (pred_set == '0) begin
                            change_mode(M_IDLE);
                        end else begin
                            pred_set = pred_set - 1'b1;
                            if (pred_elapsed != '1)
                                pred_elapsed = pred_elapsed + 1'b1;
                            show_value(PROD_W'(pred_set));
                            if (pred_set == '0)
                                change_mode(M_IDLE);
                        end
                    end
                end
            end
            M_PAUSE: begin
                if (cmd == EV_START) begin
                    change_mode(M_COUNT);
                end else if (cmd == EV_INC) begin
                    add_step();
                    change_mode(M_SET);
                end else if (cmd == EV_DEC && pred_set >= pred_step) begin
                    pred_set = pred_set - pred_step;
                    change_mode(M_SET);
                end
            end
            M_STAT: begin
                if (cmd == EV_TICK && phase == pred_second)
                    change_mode(M_IDLE);
            end
            default: ;
        endcase
        pred_out.mode = pred_mode;
        results_due.push_back(pred_out);
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 40)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    task automatic push_event(cmd_t cmd, logic [PHASE_W-1:0] phase);
        events_pending.push_back('{cmd: cmd, phase: phase});
        queued_count++;
    endtask

    task automatic wait_drained();
        do begin
            @(posedge aclk);
            #1;
        end while (events_pending.size() != 0 || s_valid || results_due.size() != 0);
    endtask

    task automatic apply_settings(logic [STEP_W-1:0] step, logic [PHASE_W-1:0] beep,
                                  logic [PHASE_W-1:0] second);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_STEP;
        cfg_wdata <= step;
        @(negedge aclk);
        cfg_index <= CFG_BEEP_PHASE;
        cfg_wdata <= CFG_DATA_W'(beep);
        @(negedge aclk);
        cfg_index <= CFG_SECOND_PHASE;
        cfg_wdata <= CFG_DATA_W'(second);
        @(negedge aclk);
        cfg_we <= 1'b0;
        gen_beep = beep;
        gen_second = second;
        @(posedge aclk);
        #1;
    endtask

    // event driver: a word stays up until it is taken
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_took)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (events_pending.size() != 0) begin
                next_ev = events_pending.pop_front();
                s_cmd <= next_ev.cmd;
                s_phase <= next_ev.phase;
                s_valid <= 1'b1;
                send_gap = idling ? $urandom_range(0, 8) : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result sink: while idling is set, holds ready low for a random stall after each word
    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_took)
                stall_left = idling ? $urandom_range(0, 8) : 0;
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            pred_mode = M_IDLE;
            pred_set = '0;
            pred_elapsed = '0;
            pred_prod = '0;
            pred_step = STEP_RESET;
            pred_beep = BEEP_PHASE_RESET;
            pred_second = SECOND_PHASE_RESET;
            in_took <= 1'b0;
            out_took <= 1'b0;
        end else if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            cycle_count++;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_STEP:         pred_step = cfg_wdata[STEP_W-1:0];
                    CFG_BEEP_PHASE:   pred_beep = cfg_wdata[PHASE_W-1:0];
                    CFG_SECOND_PHASE: pred_second = cfg_wdata[PHASE_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 40)
                        $display("%0t: result word, expected none, got mode %0d status %0d",
                                 $time, m_mode, m_status);
                end else begin
                    due = results_due.pop_front();
                    check_field("mode", 32'(due.mode), 32'(m_mode));
                    check_field("show_time", 32'(due.show_time), 32'(m_show_time));
                    check_field("display_seconds", 32'(due.display_seconds),
                                32'(m_display_seconds));
                    check_field("message", 32'(due.message), 32'(m_message));
                    check_field("beep", 32'(due.beep), 32'(m_beep));
                    check_field("status", 32'(due.status), 32'(m_status));
                end
            end
            if (s_valid && s_ready)
                predict_event(cmd_t'(s_cmd), s_phase);
            in_took <= s_valid && s_ready;
            out_took <= m_valid && m_ready;
        end
    end

    initial begin
        int unsigned phase_step[8];
        int unsigned phase_beep[8];
        int unsigned phase_second[8];
        int unsigned start_count;
        int unsigned steer_ticks;
        int          pick;

        phase_step = '{1, 2, 0, 3, 1023, 600, 1, 5};
        // 16 means draw the phase at random
        phase_beep = '{0, 15, 9, 16, 16, 3, 16, 16};
        phase_second = '{15, 0, 9, 16, 16, 12, 16, 16};

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = EV_TICK;
        s_phase = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_STEP;
        cfg_wdata = '0;
        idling = 1'b1;
        gen_beep = BEEP_PHASE_RESET;
        gen_second = SECOND_PHASE_RESET;
        repeat (5) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        @(posedge aclk);
        #1;

        // register values from reset: step 60, beep at 5, second at 10
        push_event(EV_TICK, 4'd5);
        push_event(EV_TICK, 4'd4);
        push_event(EV_DEC, 4'd15);
        push_event(EV_START, 4'd0);
        push_event(EV_INC, 4'd3);
        push_event(EV_TICK, 4'd5);
        push_event(EV_TICK, 4'd10);
        push_event(EV_INC, 4'd0);
        push_event(EV_INC, 4'd15);
        push_event(EV_TICK, 4'd10);
        push_event(EV_DEC, 4'd7);
        push_event(EV_DEC, 4'd8);
        push_event(EV_DEC, 4'd1);
        // countdown started with nothing set, then tick at zero
        push_event(EV_START, 4'd2);
        push_event(EV_INC, 4'd6);
        push_event(EV_TICK, 4'd10);
        push_event(EV_INC, 4'd9);
        push_event(EV_START, 4'd11);
        push_event(EV_TICK, 4'd3);
        push_event(EV_TICK, 4'd10);
        push_event(EV_START, 4'd12);
        push_event(EV_DEC, 4'd13);
        push_event(EV_TICK, 4'd10);
        push_event(EV_INC, 4'd14);
        push_event(EV_START, 4'd0);
        push_event(EV_START, 4'd15);
        push_event(EV_DEC, 4'd5);
        wait_drained();

        // back to idle from wherever the directed words left the timer
        if (pred_mode == M_STAT) begin
            push_event(EV_TICK, gen_second);
        end else if (pred_mode != M_IDLE) begin
            if (pred_mode != M_COUNT)
                push_event(EV_START, 4'd0);
            steer_ticks = (pred_set == '0) ? 1 : 32'(pred_set);
            repeat (steer_ticks) push_event(EV_TICK, gen_second);
        end
        wait_drained();

        // saturate the set time, step it back down past the floor, count out the rest
        apply_settings(10'd1023, 4'd5, 4'd1);
        idling = 1'b0;
        repeat (70) push_event(EV_INC, rand_phase());
        repeat (65) push_event(EV_DEC, rand_phase());
        push_event(EV_START, rand_phase());
        repeat (63) push_event(EV_TICK, 4'd1);
        push_event(EV_START, rand_phase());
        push_event(EV_TICK, 4'd1);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            apply_settings(STEP_W'(phase_step[p]),
                           (phase_beep[p] > 15) ? rand_phase() : PHASE_W'(phase_beep[p]),
                           (phase_second[p] > 15) ? rand_phase()
                                                  : PHASE_W'(phase_second[p]));
            idling = (p % 3 != 2);
            start_count = queued_count;
            while (queued_count - start_count < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) == 0) begin
                    push_event(cmd_t'($urandom_range(0, 3)), rand_phase());
                end else begin
                    // set some time, run it, pause and resume, maybe look at statistics
                    if ($urandom_range(0, 2) == 0)
                        push_event(EV_TICK, gen_beep);
                    repeat ($urandom_range(1, 4)) push_event(EV_INC, rand_phase());
                    if ($urandom_range(0, 2) == 0)
                        push_event(EV_DEC, rand_phase());
                    push_event(EV_START, rand_phase());
                    repeat ($urandom_range(2, 12)) begin
                        pick = $urandom_range(0, 9);
                        if (pick < 6)
                            push_event(EV_TICK, gen_second);
                        else if (pick < 8)
                            push_event(EV_TICK, rand_phase());
                        else if (pick == 8)
                            push_event(EV_START, rand_phase());
                        else
                            push_event(cmd_t'($urandom_range(1, 2)), rand_phase());
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        push_event(EV_START, rand_phase());
                        push_event(EV_TICK, gen_second);
                    end
                end
            end
            wait_drained();
        end

        repeat (4) @(posedge aclk);
        #1;
        if (mismatch_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

### filelist.f
design/ctc_pkg.sv
design/countdown_timer_controller.sv
sim/tb.sv
